[sv/skl_pkg.sv]
package skl_pkg;

   // Fixed field widths of the ports.
   localparam int KEY_BITS     = 32;
   localparam int SLOT_BITS    = 10;
   localparam int COUNT_BITS   = 11;
   localparam int OUT_OFS_BITS = 48;

   // Opcodes of an input transaction.
   localparam logic OP_WRITE  = 1'b0;
   localparam logic OP_LOOKUP = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FINAL
   } state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic write;
      logic load;
      logic step;
      logic emit;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic more;
   } status_type;

endpackage

[sv/skl_ram.sv]
module skl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[sv/skl_ctrl.sv]
module skl_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   input  logic                opcode,
   input  skl_pkg::status_type status,
   output skl_pkg::cmd_type    cmd,
   output logic                busy
);

   skl_pkg::state_type state_ff, state_in;
   logic accept;

   assign accept = start && (state_ff == skl_pkg::ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= skl_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         skl_pkg::ST_IDLE: begin
            if (accept && (opcode == skl_pkg::OP_LOOKUP)) begin
               state_in = status.more ? skl_pkg::ST_SEARCH : skl_pkg::ST_FINAL;
            end
         end
         skl_pkg::ST_SEARCH: begin
            state_in = status.more ? skl_pkg::ST_SEARCH : skl_pkg::ST_FINAL;
         end
         skl_pkg::ST_FINAL: begin
            state_in = skl_pkg::ST_IDLE;
         end
         default: begin
            state_in = skl_pkg::ST_IDLE;
         end
      endcase
   end

   // Outputs.
   always_comb begin
      cmd  = '0;
      busy = 1'b1;
      unique case (state_ff)
         skl_pkg::ST_IDLE: begin
            busy      = 1'b0;
            cmd.write = accept && (opcode == skl_pkg::OP_WRITE);
            cmd.load  = accept && (opcode == skl_pkg::OP_LOOKUP);
         end
         skl_pkg::ST_SEARCH: begin
            cmd.step = 1'b1;
         end
         skl_pkg::ST_FINAL: begin
            cmd.emit = 1'b1;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

endmodule

[sv/skl_dpath.sv]
module skl_dpath #(
   parameter int TABLE_DEPTH = 1024,
   parameter int OFFSET_BITS = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  skl_pkg::cmd_type                    cmd,
   output skl_pkg::status_type                 status,
   input  logic [skl_pkg::SLOT_BITS-1:0]       slot,
   input  logic [skl_pkg::KEY_BITS-1:0]        search_key,
   input  logic [skl_pkg::OUT_OFS_BITS-1:0]    entry_offset,
   input  logic                                csr_wr_en,
   input  logic [skl_pkg::COUNT_BITS-1:0]      csr_wr_data,
   output logic                                rsp_valid,
   output logic                                rsp_found,
   output logic [skl_pkg::COUNT_BITS-1:0]      rsp_position,
   output logic [skl_pkg::OUT_OFS_BITS-1:0]    rsp_record_offset
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = skl_pkg::COUNT_BITS;

   logic [CW-1:0] entry_count_ff;
   logic [CW-1:0] cnt_eff;
   logic [CW-1:0] lo_ff, lo_in, hi_ff, hi_in, mid_ff, mid_in;
   logic [skl_pkg::KEY_BITS-1:0] key_ff, key_in;
   logic [skl_pkg::KEY_BITS-1:0] rd_key;
   logic [OFFSET_BITS-1:0]       rd_ofs;
   logic                         slot_ok;
   logic                         more;
   logic                         hit;

   logic                           rsp_valid_ff;
   logic                           rsp_found_ff, rsp_found_in;
   logic [CW-1:0]                  rsp_position_ff;
   logic [skl_pkg::OUT_OFS_BITS-1:0] rsp_ofs_ff, rsp_ofs_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_wr_en) begin
         entry_count_ff <= csr_wr_data;
      end
   end

   // A count beyond the table is clamped to the table depth.
   assign cnt_eff = (32'(entry_count_ff) > 32'(TABLE_DEPTH)) ? CW'(TABLE_DEPTH)
                                                             : entry_count_ff;

   assign slot_ok = 32'(slot) < 32'(TABLE_DEPTH);

   // Search bounds. The read address for the next cycle is the new midpoint
   // while the interval is open, and the lower bound once it has closed.
   always_comb begin
      lo_in  = lo_ff;
      hi_in  = hi_ff;
      key_in = key_ff;
      if (cmd.load) begin
         lo_in  = '0;
         hi_in  = cnt_eff;
         key_in = search_key;
      end else if (cmd.step) begin
         if (rd_key < key_ff) begin
            lo_in = mid_ff + CW'(1);
         end else begin
            hi_in = mid_ff;
         end
      end
      more   = lo_in < hi_in;
      mid_in = more ? (lo_in + ((hi_in - lo_in) >> 1)) : lo_in;
   end

   assign status.more = more;

   always_ff @(posedge clock) begin
      lo_ff  <= lo_in;
      hi_ff  <= hi_in;
      mid_ff <= mid_in;
      key_ff <= key_in;
   end

   skl_ram #(
      .WIDTH(skl_pkg::KEY_BITS),
      .DEPTH(TABLE_DEPTH)
   ) u_key_ram (
      .clock  (clock),
      .wr_en  (cmd.write && slot_ok),
      .wr_addr(AW'(slot)),
      .wr_data(search_key),
      .rd_addr(AW'(mid_in)),
      .rd_data(rd_key)
   );

   skl_ram #(
      .WIDTH(OFFSET_BITS),
      .DEPTH(TABLE_DEPTH)
   ) u_ofs_ram (
      .clock  (clock),
      .wr_en  (cmd.write && slot_ok),
      .wr_addr(AW'(slot)),
      .wr_data(OFFSET_BITS'(entry_offset)),
      .rd_addr(AW'(mid_in)),
      .rd_data(rd_ofs)
   );

   // Final check on the entry at the lower bound.
   always_comb begin
      hit          = (lo_ff < cnt_eff) && (rd_key == key_ff);
      rsp_found_in = hit;
      rsp_ofs_in   = hit ? skl_pkg::OUT_OFS_BITS'(rd_ofs) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.emit;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_found_ff    <= rsp_found_in;
         rsp_position_ff <= lo_ff;
         rsp_ofs_ff      <= rsp_ofs_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_found         = rsp_found_ff;
   assign rsp_position      = rsp_position_ff;
   assign rsp_record_offset = rsp_ofs_ff;

endmodule

[sv/sorted_key_table_lookup.sv]
// Channel     Ports                                   Handshake
// ----------  --------------------------------------  -------------------------------
// request     req_opcode, req_slot, req_search_key,   accepted when start && !busy
//             req_entry_offset
// response    rsp_found, rsp_position,                rsp_valid strobe, one cycle
//             rsp_record_offset
// csr         csr_wr_data (entry_count)               written when csr_wr_en is high
//
// A write is taken while idle and busy stays low. A lookup holds busy high
// through its search probes, at most ceil(log2(n + 1)) for n entries (11 at
// 1024), and the final check: the single registered read port of the key
// memory gives one probe per cycle. The result strobes in the first cycle with
// busy low again. Reset clears the controller, entry_count and the strobe, not
// the table. The receiver cannot stall the response.
//
// The controller steps the search; the datapath holds the bounds, the query
// key, the two table memories and the response register.
module sorted_key_table_lookup #(
   parameter int TABLE_DEPTH = 1024,
   parameter int OFFSET_BITS = 48
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic                                req_opcode,
   input  logic [skl_pkg::SLOT_BITS-1:0]       req_slot,
   input  logic [skl_pkg::KEY_BITS-1:0]        req_search_key,
   input  logic [skl_pkg::OUT_OFS_BITS-1:0]    req_entry_offset,
   input  logic                                csr_wr_en,
   input  logic [skl_pkg::COUNT_BITS-1:0]      csr_wr_data,
   output logic                                rsp_valid,
   output logic                                rsp_found,
   output logic [skl_pkg::COUNT_BITS-1:0]      rsp_position,
   output logic [skl_pkg::OUT_OFS_BITS-1:0]    rsp_record_offset
);

   skl_pkg::cmd_type    cmd;
   skl_pkg::status_type status;

   // The controller sequences each transaction and raises busy during lookups.
   skl_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .opcode(req_opcode),
      .status(status),
      .cmd   (cmd),
      .busy  (busy)
   );

   // The datapath stores the table, narrows the search interval and forms
   // the response once the interval has closed.
   skl_dpath #(
      .TABLE_DEPTH(TABLE_DEPTH),
      .OFFSET_BITS(OFFSET_BITS)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .slot             (req_slot),
      .search_key       (req_search_key),
      .entry_offset     (req_entry_offset),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .rsp_valid        (rsp_valid),
      .rsp_found        (rsp_found),
      .rsp_position     (rsp_position),
      .rsp_record_offset(rsp_record_offset)
   );

endmodule
